// ===== hdl/sldf_pkg.sv =====
// Shared types and constants for the sync/length frame deframer.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package sldf_pkg;

  // Default header length in bytes (sync, length, id, format, spare bytes).
  localparam int HEADER_BYTES_DEF = 16;

  // Header offsets of the fields after the four sync bytes.
  localparam int OFS_FIRST_AFTER_SYNC = 4;
  localparam int OFS_LEN_LO           = 4;
  localparam int OFS_LEN_HI           = 5;
  localparam int OFS_ID_LO            = 6;
  localparam int OFS_ID_HI            = 7;
  localparam int OFS_FORMAT           = 8;

  // One result item as it leaves the deframer.
  typedef struct packed {
    logic        empty_frame;
    logic        last_of_frame;
    logic        first_of_frame;
    logic [7:0]  format_code;
    logic [15:0] message_id;
    logic [7:0]  payload_byte;
  } result_t;

endpackage : sldf_pkg

`default_nettype wire

// ===== hdl/sldf_core.sv =====
// Deframer state machine: sync hunt, header parse and payload marking.
// Depends on sldf_pkg for the result type and header offsets.
`timescale 1ns / 1ps
`default_nettype none

module sldf_core #(
  parameter int HEADER_BYTES = sldf_pkg::HEADER_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [31:0]       sync_pattern,
  output logic                   res_valid,
  output sldf_pkg::result_t      res
);

  localparam int HPOS_W = $clog2(HEADER_BYTES);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [HPOS_W-1:0] POS_START  = HPOS_W'(sldf_pkg::OFS_FIRST_AFTER_SYNC);
  localparam logic [HPOS_W-1:0] POS_LEN_LO = HPOS_W'(sldf_pkg::OFS_LEN_LO);
  localparam logic [HPOS_W-1:0] POS_LEN_HI = HPOS_W'(sldf_pkg::OFS_LEN_HI);
  localparam logic [HPOS_W-1:0] POS_ID_LO  = HPOS_W'(sldf_pkg::OFS_ID_LO);
  localparam logic [HPOS_W-1:0] POS_ID_HI  = HPOS_W'(sldf_pkg::OFS_ID_HI);
  localparam logic [HPOS_W-1:0] POS_FORMAT = HPOS_W'(sldf_pkg::OFS_FORMAT);
  localparam logic [HPOS_W-1:0] POS_LAST   = HPOS_W'(HEADER_BYTES - 1);

  logic [1:0]        phase,  phase_next;
  logic [23:0]       window, window_next;
  logic [1:0]        fill,   fill_next;
  logic [HPOS_W-1:0] hpos,   hpos_next;
  logic [15:0]       length, length_next;
  logic [15:0]       id,     id_next;
  logic [7:0]        fmt,    fmt_next;
  logic [15:0]       remain, remain_next;
  logic [15:0]       remain_dec;

  assign remain_dec = (remain != 16'd0) ? remain - 16'd1 : remain;

  // Next-state and result logic for one accepted byte.
  always_comb begin
    phase_next  = phase;
    window_next = window;
    fill_next   = fill;
    hpos_next   = hpos;
    length_next = length;
    id_next     = id;
    fmt_next    = fmt;
    remain_next = remain;
    res_valid   = 1'b0;
    res         = '0;

    unique case (phase)
      PH_HEADER: begin
        if (hpos == POS_LEN_LO) length_next = {length[15:8], rx_byte};
        if (hpos == POS_LEN_HI) length_next = {rx_byte, length[7:0]};
        if (hpos == POS_ID_LO)  id_next     = {id[15:8], rx_byte};
        if (hpos == POS_ID_HI)  id_next     = {rx_byte, id[7:0]};
        if (hpos == POS_FORMAT) fmt_next    = rx_byte;
        if (hpos == POS_LAST) begin
          hpos_next = '0;
          if (length_next == 16'd0) begin
            // Zero-length frame: one marker result, then hunt again.
            res_valid          = 1'b1;
            res.message_id     = id_next;
            res.format_code    = fmt_next;
            res.first_of_frame = 1'b1;
            res.last_of_frame  = 1'b1;
            res.empty_frame    = 1'b1;
            phase_next  = PH_HUNT;
            window_next = '0;
            fill_next   = '0;
          end else begin
            remain_next = length_next;
            phase_next  = PH_PAYLOAD;
          end
        end else begin
          hpos_next = hpos + HPOS_W'(1);
        end
      end
      PH_PAYLOAD: begin
        res_valid          = 1'b1;
        res.payload_byte   = rx_byte;
        res.message_id     = id;
        res.format_code    = fmt;
        res.first_of_frame = (remain == length);
        res.last_of_frame  = (remain <= 16'd1);
        remain_next = remain_dec;
        if (remain_dec == 16'd0) begin
          phase_next  = PH_HUNT;
          window_next = '0;
          fill_next   = '0;
        end
      end
      default: begin
        // Hunting; the unused phase code behaves the same way.
        phase_next = PH_HUNT;
        if (fill == 2'd3 && {window, rx_byte} == sync_pattern) begin
          phase_next  = PH_HEADER;
          hpos_next   = POS_START;
          window_next = '0;
          fill_next   = '0;
        end else begin
          window_next = {window[15:0], rx_byte};
          if (fill != 2'd3) fill_next = fill + 2'd1;
        end
      end
    endcase
  end

  // State registers advance only on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HUNT;
      window <= '0;
      fill   <= '0;
      hpos   <= '0;
      length <= '0;
      id     <= '0;
      fmt    <= '0;
      remain <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      window <= window_next;
      fill   <= fill_next;
      hpos   <= hpos_next;
      length <= length_next;
      id     <= id_next;
      fmt    <= fmt_next;
      remain <= remain_next;
    end
  end

endmodule : sldf_core

`default_nettype wire

// ===== hdl/sldf_out_queue.sv =====
// Two-entry result queue that decouples the deframer from the output stream.
// Depends on sldf_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module sldf_out_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sldf_pkg::result_t push_data,
  output logic                   not_full,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output sldf_pkg::result_t      pop_data
);

  sldf_pkg::result_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign not_full  = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = entry[rd_ptr];
  assign pop       = pop_valid && pop_ready;

  // Storage is written at the tail; no reset is needed for payload.
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  // Pointers and occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule : sldf_out_queue

`default_nettype wire

// ===== hdl/sync_length_frame_deframer.sv =====
// Sync-word, length-prefixed byte deframer, top level.
// A payload result is written into the output queue at the edge that accepts its byte.
// Throughput: one byte per cycle; the two-entry output queue keeps accepting
// while one result waits, and input ready drops only when both entries hold.
// Reset (rst, synchronous, active high) clears the hunt, the header state,
// the sync register and the queue; the block is ready the cycle after.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_frame_deframer #(
  parameter int HEADER_BYTES = sldf_pkg::HEADER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] payload_byte, [23:8] message_id,
                                      // [31:24] format_code
  output logic             m_tlast,   // last_of_frame
  output logic [1:0]       m_tuser,   // [0] first_of_frame, [1] empty_frame
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data   // sync_pattern
);

  logic              accept;
  logic              res_valid;
  logic              not_full;
  logic [31:0]       sync_pattern;
  sldf_pkg::result_t res;
  sldf_pkg::result_t out_res;

  assign s_tready  = not_full;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Sync pattern register.
  always_ff @(posedge clk) begin
    if (rst) sync_pattern <= '0;
    else if (cfg_valid && cfg_ready) sync_pattern <= cfg_data;
  end

  sldf_core #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (s_tdata),
    .sync_pattern(sync_pattern),
    .res_valid   (res_valid),
    .res         (res)
  );

  sldf_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && res_valid),
    .push_data(res),
    .not_full (not_full),
    .pop_valid(m_tvalid),
    .pop_ready(m_tready),
    .pop_data (out_res)
  );

  // Output packing.
  assign m_tdata = {out_res.format_code, out_res.message_id, out_res.payload_byte};
  assign m_tlast = out_res.last_of_frame;
  assign m_tuser = {out_res.empty_frame, out_res.first_of_frame};

  // An empty-frame marker is both first and last of its frame.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tlast && m_tuser[0]))
    else $error("empty frame marker without first/last marks");

  // An empty-frame marker carries a zero payload byte.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata[7:0] == 8'd0))
    else $error("empty frame marker with nonzero payload byte");

  // The queue is empty and ready right after reset.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (s_tready && !m_tvalid))
    else $error("deframer not idle after reset");

endmodule : sync_length_frame_deframer

`default_nettype wire

// ===== tb/tb_sync_length_frame_deframer.sv =====
// Self-checking testbench for the sync/length frame deframer.
// Depends on sldf_pkg and sync_length_frame_deframer; drives random byte streams
// with framed traffic, tracks the frame state itself and checks every result.
`timescale 1ns / 1ps

typedef logic [7:0] byte_q_t [$];

typedef enum logic [1:0] {
  HUNTING,
  IN_HEADER,
  IN_PAYLOAD
} deframe_phase_t;

// Tracks the deframer state from the accepted bytes and holds the results
// those bytes must produce, oldest first.
class deframe_scoreboard;
  logic [31:0]    sync_word;
  logic [23:0]    window;
  int             fill;
  deframe_phase_t phase;
  int             hdr_pos;
  logic [15:0]    frame_len;
  logic [15:0]    msg_id;
  logic [7:0]     fmt;
  logic [15:0]    remaining;

  sldf_pkg::result_t expected_q [$];
  int errors;
  int results_seen;
  int frames_closed;
  int empties_seen;

  function new();
    sync_word = '0;
    window    = '0;
    fill      = 0;
    phase     = HUNTING;
    hdr_pos   = 0;
    frame_len = '0;
    msg_id    = '0;
    fmt       = '0;
    remaining = '0;
  endfunction

  function void load_sync(logic [31:0] pattern);
    sync_word = pattern;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void restart_hunt();
    phase  = HUNTING;
    window = '0;
    fill   = 0;
  endfunction

  function void add_expected(logic [7:0] data, logic first, logic last, logic empty);
    sldf_pkg::result_t r;
    r.payload_byte   = data;
    r.message_id     = msg_id;
    r.format_code    = fmt;
    r.first_of_frame = first;
    r.last_of_frame  = last;
    r.empty_frame    = empty;
    expected_q = {expected_q, r};
  endfunction

  // Advance the frame state by one accepted byte.
  function void note_input(logic [7:0] b);
    case (phase)
      IN_HEADER: begin
        case (hdr_pos)
          sldf_pkg::OFS_LEN_LO: frame_len[7:0] = b;
          sldf_pkg::OFS_LEN_HI: frame_len[15:8] = b;
          sldf_pkg::OFS_ID_LO:  msg_id[7:0] = b;
          sldf_pkg::OFS_ID_HI:  msg_id[15:8] = b;
          sldf_pkg::OFS_FORMAT: fmt = b;
          default: ;
        endcase
        if (hdr_pos + 1 >= sldf_pkg::HEADER_BYTES_DEF) begin
          hdr_pos = 0;
          if (frame_len == 0) begin
            // A zero-length frame closes on its last header byte.
            add_expected(8'h00, 1'b1, 1'b1, 1'b1);
            restart_hunt();
          end else begin
            remaining = frame_len;
            phase = IN_PAYLOAD;
          end
        end else begin
          hdr_pos++;
        end
      end
      IN_PAYLOAD: begin
        add_expected(b, remaining == frame_len, remaining <= 1, 1'b0);
        if (remaining > 0) remaining--;
        if (remaining == 0) restart_hunt();
      end
      default: begin
        // No match is possible until three bytes sit in the window.
        phase = HUNTING;
        if (fill >= 3 && {window, b} == sync_word) begin
          phase   = IN_HEADER;
          hdr_pos = sldf_pkg::OFS_FIRST_AFTER_SYNC;
          window  = '0;
          fill    = 0;
        end else begin
          window = {window[15:0], b};
          if (fill < 3) fill++;
        end
      end
    endcase
  endfunction

  task report(string what);
    errors++;
    $display("tb: mismatch at %0t ns: %s", $time, what);
  endtask

  task compare(string field, int unsigned got, int unsigned want);
    if (got != want)
      report($sformatf("result %0d %s is 0x%0h, expected 0x%0h",
                       results_seen, field, got, want));
  endtask

  task check_result(sldf_pkg::result_t got);
    sldf_pkg::result_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected", results_seen));
      return;
    end
    want = expected_q.pop_front();
    compare("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
    compare("message_id", 32'(got.message_id), 32'(want.message_id));
    compare("format_code", 32'(got.format_code), 32'(want.format_code));
    compare("first_of_frame", 32'(got.first_of_frame), 32'(want.first_of_frame));
    compare("last_of_frame", 32'(got.last_of_frame), 32'(want.last_of_frame));
    compare("empty_frame", 32'(got.empty_frame), 32'(want.empty_frame));
    if (want.last_of_frame) frames_closed++;
    if (want.empty_frame) empties_seen++;
  endtask

  task check_leftovers();
    if (expected_q.size() != 0)
      report($sformatf("%0d expected results never arrived", expected_q.size()));
  endtask
endclass

module tb_sync_length_frame_deframer;

  localparam int RANDOM_ITEMS  = 500;
  localparam int PHASE_ITEMS   = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_PAYLOAD  = 40;
  localparam longint TIMEOUT_NS = 5_000_000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  deframe_scoreboard sb;
  bit tx_calm;
  bit hold_request;
  bit hold_done;
  int bytes_sent;
  int cfg_writes;

  sync_length_frame_deframer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic byte_q_t rand_bytes(int n, bit avoid_on, logic [7:0] avoid);
    byte_q_t q;
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      while (avoid_on && b == avoid) b = 8'($urandom_range(0, 255));
      q = {q, b};
    end
    return q;
  endfunction

  // Sync bytes first byte first, then length and id little-endian, format, spares.
  function automatic byte_q_t build_header(logic [31:0] sync, logic [15:0] len,
                                           logic [15:0] id, logic [7:0] fmt);
    byte_q_t q;
    q = '{sync[31:24], sync[23:16], sync[15:8], sync[7:0],
          len[7:0], len[15:8], id[7:0], id[15:8], fmt};
    while (q.size() < sldf_pkg::HEADER_BYTES_DEF) q = {q, 8'($urandom_range(0, 255))};
    return q;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // Stop offering bytes and wait until every expected result is out, then
  // give the block a few cycles to finish any header byte in flight.
  task automatic wait_drained();
    int guard;
    s_tvalid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic [31:0] pattern);
    cfg_valid <= 1'b1;
    cfg_data  <= pattern;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.load_sync(pattern);
    cfg_writes++;
  endtask

  // Result side: random stalls in stretches, calm stretches, and one long
  // hold-off on request from the stimulus.
  initial begin : result_sink
    sldf_pkg::result_t got;
    int stall_left;
    int mode_left;
    bit calm;
    stall_left = 0;
    mode_left  = 0;
    calm       = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.payload_byte   = m_tdata[7:0];
        got.message_id     = m_tdata[23:8];
        got.format_code    = m_tdata[31:24];
        got.first_of_frame = m_tuser[0];
        got.empty_frame    = m_tuser[1];
        got.last_of_frame  = m_tlast;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (mode_left == 0) begin
          calm = ($urandom_range(0, 2) == 0);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        if (!calm) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    byte_q_t hdr;
    logic [31:0] pattern;
    logic [15:0] len;
    logic [7:0] brk;
    int rand_start;
    int phase_start;
    int phase_no;
    int pick;
    int cut;

    sb = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    tx_calm = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset pattern of zero, empty frame with all-ones id and format.
    send_byte(8'h5A);
    send_bytes(build_header(32'h0, 16'h0000, 16'hFFFF, 8'hFF));
    // One-byte frame: first and last on the same result.
    send_bytes(build_header(32'h0, 16'h0001, 16'h0000, 8'h00));
    send_byte(8'hFF);
    // Near miss on sync, then a two-byte frame.
    send_bytes('{8'h00, 8'h00, 8'h00, 8'h01});
    send_bytes(build_header(32'h0, 16'h0002, 16'h1234, 8'h5A));
    send_bytes('{8'h00, 8'h80});

    // New sync pattern written while the block sits inside a header.
    hdr = build_header(32'h0, 16'h0003, 16'hA55A, 8'h3C);
    for (int i = 0; i < 10; i++) send_byte(hdr[i]);
    wait_drained();
    write_sync(32'hFFFF_FFFF);
    for (int i = 10; i < sldf_pkg::HEADER_BYTES_DEF; i++) send_byte(hdr[i]);
    send_bytes('{8'h01, 8'h02, 8'h7F});
    send_bytes(build_header(32'hFFFF_FFFF, 16'h0000, 16'h0001, 8'h80));

    // Sync pattern repeated inside the payload must not restart the frame.
    wait_drained();
    write_sync(32'hA5A5_A5A5);
    send_bytes(build_header(32'hA5A5_A5A5, 16'h0004, 16'h00FF, 8'h01));
    send_bytes('{8'hA5, 8'hA5, 8'hA5, 8'hA5});

    // Random phases, each under its own sync pattern.
    rand_start = bytes_sent;
    phase_no   = 0;
    while (bytes_sent - rand_start < RANDOM_ITEMS) begin
      wait_drained();
      case (phase_no)
        1: pattern = 32'h0000_0000;
        2: pattern = 32'hFFFF_FFFF;
        default: pattern = $urandom();
      endcase
      write_sync(pattern);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          // Line noise that cannot start the pattern.
          send_bytes(rand_bytes($urandom_range(1, 6), 1'b1, pattern[31:24]));
        end else if (pick < 30) begin
          // Partial sync broken off by a byte that neither continues it nor restarts it.
          cut = $urandom_range(1, 3);
          for (int i = 0; i < cut; i++) send_byte(pattern[31 - 8 * i -: 8]);
          brk = 8'($urandom_range(0, 255));
          while (brk == pattern[31 - 8 * cut -: 8] || brk == pattern[31:24])
            brk = 8'($urandom_range(0, 255));
          send_byte(brk);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) len = 16'($urandom_range(0, 8));
        else if (pick < 95) len = 16'($urandom_range(9, 40));
        else len = 16'($urandom_range(41, 300));
        if (!hold_done && bytes_sent - rand_start > 200 && len >= 20) begin
          hold_request = 1'b1;
          hold_done = 1'b1;
        end
        send_bytes(build_header(pattern, len, 16'($urandom_range(0, 65535)),
                                8'($urandom_range(0, 255))));
        send_bytes(rand_bytes(len, 1'b0, 8'h00));
      end
      phase_no++;
    end

    // Last: a maximum-length frame, of which only the opening bytes are sent.
    wait_drained();
    pattern = $urandom();
    write_sync(pattern);
    tx_calm = 1'b0;
    if (!hold_done) begin
      hold_request = 1'b1;
      hold_done = 1'b1;
    end
    send_bytes(build_header(pattern, 16'hFFFF, 16'($urandom_range(0, 65535)),
                            8'($urandom_range(0, 255))));
    send_bytes(rand_bytes(TAIL_PAYLOAD, 1'b0, 8'h00));
    wait_drained();

    sb.check_leftovers();
    $display("tb: %0d bytes sent under %0d sync settings, %0d results checked",
             bytes_sent, cfg_writes + 1, sb.results_seen);
    $display("tb: %0d frames closed, %0d of them empty, one %0d-cycle output hold-off",
             sb.frames_closed, sb.empties_seen, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
